// ===== hw/rtl/rcre_pkg.sv =====
// Shared types, constants and frame builder for the relay command retry engine.
// No dependencies.
`default_nettype none

package rcre_pkg;

   localparam int FRAME_BYTES   = 9;
   localparam int FRAME_IDX_W   = 4;
   localparam int REPLY_SUM_CNT = FRAME_BYTES - 1;
   localparam int STATUS_POS    = 6;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   localparam logic [7:0] SYNC_BYTE_A = 8'h5A;
   localparam logic [7:0] SYNC_BYTE_B = 8'h51;

   localparam logic [3:0] TIMEOUT_LIMIT_RESET = 4'd3;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      OP_START      = 2'd0,
      OP_BYTE       = 2'd1,
      OP_TIMEOUT    = 2'd2,
      OP_LINE_ERROR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_TX   = 2'd0,
      KIND_OK   = 2'd1,
      KIND_FAIL = 2'd2
   } kind_type;

   typedef enum logic {
      REG_TIMEOUT_LIMIT   = 1'b0,
      REG_SWITCH_POLARITY = 1'b1
   } reg_type;

   // work item handed from the front to the back
   typedef struct packed {
      kind_type   kind;
      logic [7:0] address;
      logic [7:0] command;
      logic       flush;
      logic [7:0] status;
      logic       switch_closed;
   } job_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] tx_byte;
      logic       frame_end;
      logic       flush_line;
      logic [7:0] status;
      logic       switch_closed;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic logic [7:0] frame_byte(input logic [FRAME_IDX_W-1:0] idx,
                                             input logic [7:0] address,
                                             input logic [7:0] command);
      logic [7:0] result;
      result = 8'h00;
      case (idx)
         FRAME_IDX_W'(1): result = SYNC_BYTE_A;
         FRAME_IDX_W'(2): result = SYNC_BYTE_B;
         FRAME_IDX_W'(3): result = address;
         FRAME_IDX_W'(4): result = command;
         FRAME_IDX_W'(FRAME_BYTES - 1):
            result = 8'(SYNC_BYTE_A + SYNC_BYTE_B + address + command);
         default: result = 8'h00;
      endcase
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/relay_command_retry_engine.sv =====
// Relay command retry engine, top level: CSRs, front, job queue, back.
// Depends on rcre_pkg, rcre_front, rcre_fifo, rcre_back.
// Path: an accepted request is written to the queue, then the back registers its result.
// Throughput: one request per cycle while the 4-entry queue is not full; back emits
// one result per cycle unless stalled by rsp_ready; 9 per frame job, 1 per other job.
// Reset: synchronous; clears control state, timeout_limit to 3, polarity to 0.
`default_nettype none

module relay_command_retry_engine
   import rcre_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_op,
   input  wire logic [7:0]            req_board_address,
   input  wire logic [7:0]            req_command_code,
   input  wire logic [7:0]            req_rx_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_kind,
   output logic [7:0]                 rsp_tx_byte,
   output logic                       rsp_frame_end,
   output logic                       rsp_flush_line,
   output logic [7:0]                 rsp_reply_status_byte,
   output logic                       rsp_switch_closed,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   logic [3:0]       timeout_limit_ff, timeout_limit_in;
   logic             polarity_ff, polarity_in;
   logic             csr_write;
   reg_type          csr_reg;
   fifo_status_type  q_status;
   logic             push, pop, busy;
   job_type          push_job, head_job;
   rsp_type          rsp;

   assign csr_pready = 1'b1;
   assign csr_reg    = reg_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      timeout_limit_in = timeout_limit_ff;
      polarity_in      = polarity_ff;
      if (csr_write) begin
         case (csr_reg)
            REG_TIMEOUT_LIMIT:   timeout_limit_in = csr_pwdata[3:0];
            REG_SWITCH_POLARITY: polarity_in      = csr_pwdata[0];
            default: ;
         endcase
      end
      case (csr_reg)
         REG_TIMEOUT_LIMIT:   csr_prdata = {{(CSR_DATA_W-4){1'b0}}, timeout_limit_ff};
         REG_SWITCH_POLARITY: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, polarity_ff};
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_limit_ff <= TIMEOUT_LIMIT_RESET;
         polarity_ff      <= 1'b0;
      end else begin
         timeout_limit_ff <= timeout_limit_in;
         polarity_ff      <= polarity_in;
      end
   end

   rcre_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_board_address (req_board_address),
      .req_command_code  (req_command_code),
      .req_rx_byte       (req_rx_byte),
      .timeout_limit     (timeout_limit_ff),
      .switch_polarity   (polarity_ff),
      .q_status          (q_status),
      .push              (push),
      .push_job          (push_job),
      .busy              (busy)
   );

   rcre_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   rcre_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_kind              = rsp.kind;
   assign rsp_tx_byte           = rsp.tx_byte;
   assign rsp_frame_end         = rsp.frame_end;
   assign rsp_flush_line        = rsp.flush_line;
   assign rsp_reply_status_byte = rsp.status;
   assign rsp_switch_closed     = rsp.switch_closed;

   assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue both full and empty");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp.kind == KIND_TX)
      else $error("frame end on a non-transmit result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.kind == KIND_OK |-> !rsp_flush_line)
      else $error("flush requested on a done result");

   assert property (@(posedge clock)
      $past(reset) |-> !busy && !rsp_valid)
      else $error("engine not idle after reset");

endmodule

`default_nettype wire

// ===== hw/rtl/rcre_fifo.sv =====
// Short job queue between the front and back parts.
// Depends on rcre_pkg.
`default_nettype none

module rcre_fifo
   import rcre_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire job_type         push_job,
   input  wire logic            pop,
   output job_type              head_job,
   output fifo_status_type      status
);

   job_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign status.full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_job     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rcre_front.sv =====
// Front part: accepts requests, tracks the reply and retry state, queues jobs.
// Depends on rcre_pkg.
`default_nettype none

module rcre_front
   import rcre_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [7:0]  req_board_address,
   input  wire logic [7:0]  req_command_code,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic [3:0]  timeout_limit,
   input  wire logic        switch_polarity,
   input  wire fifo_status_type q_status,
   output logic             push,
   output job_type          push_job,
   output logic             busy
);

   logic                    busy_ff, busy_in;
   logic [7:0]              held_addr_ff, held_addr_in;
   logic [7:0]              held_cmd_ff, held_cmd_in;
   logic [FRAME_IDX_W-1:0]  reply_count_ff, reply_count_in;
   logic [7:0]              reply_sum_ff, reply_sum_in;
   logic [7:0]              byte_six_ff, byte_six_in;
   logic [3:0]              tmo_tally_ff, tmo_tally_in;
   logic [3:0]              timeout_next;
   logic                    accept;
   op_type                  op;

   assign req_ready    = !q_status.full;
   assign accept       = req_valid && req_ready;
   assign op           = op_type'(req_op);
   assign timeout_next = tmo_tally_ff + 4'd1;
   assign busy         = busy_ff;

   always_comb begin
      busy_in          = busy_ff;
      held_addr_in     = held_addr_ff;
      held_cmd_in      = held_cmd_ff;
      reply_count_in   = reply_count_ff;
      reply_sum_in     = reply_sum_ff;
      byte_six_in      = byte_six_ff;
      tmo_tally_in     = tmo_tally_ff;
      push             = 1'b0;
      push_job         = '{kind: KIND_TX, address: held_addr_ff, command: held_cmd_ff,
                           flush: 1'b0, status: 8'h00, switch_closed: 1'b0};
      if (accept) begin
         if (op == OP_START) begin
            busy_in          = 1'b1;
            held_addr_in     = req_board_address;
            held_cmd_in      = req_command_code;
            reply_count_in   = '0;
            reply_sum_in     = '0;
            byte_six_in      = '0;
            tmo_tally_in     = '0;
            push             = 1'b1;
            push_job.address = req_board_address;
            push_job.command = req_command_code;
         end else if (busy_ff) begin
            case (op)
               OP_BYTE: begin
                  if (reply_count_ff < FRAME_IDX_W'(REPLY_SUM_CNT)) begin
                     reply_sum_in   = reply_sum_ff + req_rx_byte;
                     reply_count_in = reply_count_ff + 1'b1;
                     if (reply_count_ff == FRAME_IDX_W'(STATUS_POS)) begin
                        byte_six_in = req_rx_byte;
                     end
                  end else begin
                     reply_count_in = '0;
                     reply_sum_in   = '0;
                     byte_six_in    = '0;
                     push           = 1'b1;
                     if (reply_sum_ff == req_rx_byte) begin
                        busy_in                = 1'b0;
                        push_job.kind          = KIND_OK;
                        push_job.status        = byte_six_ff;
                        push_job.switch_closed = ~(byte_six_ff[0] ^ switch_polarity);
                     end else begin
                        push_job.flush = 1'b1;
                     end
                  end
               end
               OP_TIMEOUT: begin
                  reply_count_in = '0;
                  reply_sum_in   = '0;
                  byte_six_in    = '0;
                  push           = 1'b1;
                  if (timeout_next >= timeout_limit) begin
                     busy_in          = 1'b0;
                     tmo_tally_in     = '0;
                     push_job.kind    = KIND_FAIL;
                     push_job.flush   = 1'b1;
                  end else begin
                     tmo_tally_in = timeout_next;
                  end
               end
               default: begin
                  busy_in        = 1'b0;
                  reply_count_in = '0;
                  reply_sum_in   = '0;
                  byte_six_in    = '0;
                  push           = 1'b1;
                  push_job.kind  = KIND_FAIL;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff          <= 1'b0;
         held_addr_ff     <= '0;
         held_cmd_ff      <= '0;
         reply_count_ff   <= '0;
         reply_sum_ff     <= '0;
         byte_six_ff      <= '0;
         tmo_tally_ff     <= '0;
      end else begin
         busy_ff          <= busy_in;
         held_addr_ff     <= held_addr_in;
         held_cmd_ff      <= held_cmd_in;
         reply_count_ff   <= reply_count_in;
         reply_sum_ff     <= reply_sum_in;
         byte_six_ff      <= byte_six_in;
         tmo_tally_ff     <= tmo_tally_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rcre_back.sv =====
// Back part: drains queued jobs, serializes frames and registers each result.
// Depends on rcre_pkg.
`default_nettype none

module rcre_back
   import rcre_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire job_type         head_job,
   input  wire fifo_status_type q_status,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_type              rsp
);

   localparam logic [FRAME_IDX_W-1:0] LAST_IDX = FRAME_IDX_W'(FRAME_BYTES - 1);

   job_type                 job_ff, job_in;
   logic                    active_ff, active_in;
   logic [FRAME_IDX_W-1:0]  idx_ff, idx_in;
   logic                    valid_ff, valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    load;

   assign load      = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      job_in    = job_ff;
      active_in = active_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff && !rsp_ready;
      rsp_in    = rsp_ff;
      pop       = 1'b0;
      if (load) begin
         if (active_ff) begin
            valid_in = 1'b1;
            rsp_in   = '{kind: KIND_TX,
                         tx_byte: frame_byte(idx_ff, job_ff.address, job_ff.command),
                         frame_end: (idx_ff == LAST_IDX), flush_line: 1'b0,
                         status: 8'h00, switch_closed: 1'b0};
            idx_in   = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               active_in = 1'b0;
            end
         end else if (!q_status.empty) begin
            pop      = 1'b1;
            valid_in = 1'b1;
            job_in   = head_job;
            rsp_in   = '{kind: head_job.kind, tx_byte: 8'h00, frame_end: 1'b0,
                         flush_line: head_job.flush, status: 8'h00,
                         switch_closed: 1'b0};
            case (head_job.kind)
               KIND_TX: begin
                  rsp_in.tx_byte = frame_byte('0, head_job.address, head_job.command);
                  active_in      = 1'b1;
                  idx_in         = FRAME_IDX_W'(1);
               end
               KIND_OK: begin
                  rsp_in.status        = head_job.status;
                  rsp_in.switch_closed = head_job.switch_closed;
               end
               default: begin
                  rsp_in.kind = KIND_FAIL;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== bench/relay_command_retry_engine_tb.sv =====
// Self-checking bench for relay_command_retry_engine: queued requests, APB register
// writes between phases, result prediction at request acceptance, field-wise compare.
// Depends on rcre_pkg and the relay_command_retry_engine RTL.

module relay_command_retry_engine_tb;
   import rcre_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 10;

   localparam logic [7:0] CMD_ON    = 8'h01;
   localparam logic [7:0] CMD_OFF   = 8'h02;
   localparam logic [7:0] CMD_QUERY = 8'h07;

   typedef struct {
      op_type     op;
      logic [7:0] address;
      logic [7:0] command;
      logic [7:0] rx_byte;
   } relay_request_type;

   typedef struct {
      kind_type   kind;
      logic [7:0] tx_byte;
      logic       frame_end;
      logic       flush_line;
      logic [7:0] status;
      logic       switch_closed;
   } relay_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_op = '0;
   logic [7:0]            req_board_address = '0;
   logic [7:0]            req_command_code = '0;
   logic [7:0]            req_rx_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_kind;
   logic [7:0]            rsp_tx_byte;
   logic                  rsp_frame_end;
   logic                  rsp_flush_line;
   logic [7:0]            rsp_reply_status_byte;
   logic                  rsp_switch_closed;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   relay_command_retry_engine u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_op                (req_op),
      .req_board_address     (req_board_address),
      .req_command_code      (req_command_code),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_kind              (rsp_kind),
      .rsp_tx_byte           (rsp_tx_byte),
      .rsp_frame_end         (rsp_frame_end),
      .rsp_flush_line        (rsp_flush_line),
      .rsp_reply_status_byte (rsp_reply_status_byte),
      .rsp_switch_closed     (rsp_switch_closed),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   // register copies and engine state mirror
   logic [3:0] cfg_timeout_limit = TIMEOUT_LIMIT_RESET;
   logic       cfg_polarity = 1'b0;
   logic       relay_busy = 1'b0;
   logic [7:0] relay_address = '0;
   logic [7:0] relay_command = '0;
   logic [3:0] reply_count = '0;
   logic [7:0] reply_sum = '0;
   logic [7:0] reply_six = '0;
   logic [3:0] tmo_tally = '0;

   relay_request_type requests_todo[$];
   relay_result_type  relay_results_due[$];
   relay_request_type drive_item;

   bit gaps_on = 1'b1;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int failures = 0;
   int requests_sent = 0;
   int tx_seen = 0;
   int done_seen = 0;
   int failed_seen = 0;

   always #2 clock = ~clock;

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   function automatic void clear_reply_progress();
      reply_count = '0;
      reply_sum = '0;
      reply_six = '0;
   endfunction

   function automatic void queue_frame(logic flush_first);
      logic [7:0]       bytes [FRAME_BYTES];
      relay_result_type r;
      int               i;
      foreach (bytes[j]) bytes[j] = 8'h00;
      bytes[1] = SYNC_BYTE_A;
      bytes[2] = SYNC_BYTE_B;
      bytes[3] = relay_address;
      bytes[4] = relay_command;
      bytes[FRAME_BYTES-1] = bytes[1] + bytes[2] + bytes[3] + bytes[4];
      for (i = 0; i < FRAME_BYTES; i++) begin
         r.kind = KIND_TX;
         r.tx_byte = bytes[i];
         r.frame_end = (i == FRAME_BYTES - 1);
         r.flush_line = (i == 0) ? flush_first : 1'b0;
         r.status = 8'h00;
         r.switch_closed = 1'b0;
         relay_results_due.push_back(r);
      end
   endfunction

   function automatic void queue_verdict(kind_type k, logic flush, logic [7:0] status,
                                         logic closed);
      relay_result_type r;
      r.kind = k;
      r.tx_byte = 8'h00;
      r.frame_end = 1'b0;
      r.flush_line = flush;
      r.status = status;
      r.switch_closed = closed;
      relay_results_due.push_back(r);
   endfunction

   function automatic void relay_engine_step(relay_request_type q);
      if (q.op == OP_START) begin
         relay_address = q.address;
         relay_command = q.command;
         relay_busy = 1'b1;
         clear_reply_progress();
         tmo_tally = '0;
         queue_frame(1'b0);
      end else if (relay_busy) begin
         case (q.op)
            OP_BYTE: begin
               if (reply_count < FRAME_BYTES - 1) begin
                  reply_sum = reply_sum + q.rx_byte;
                  if (reply_count == STATUS_POS) reply_six = q.rx_byte;
                  reply_count = reply_count + 1'b1;
               end else if (reply_sum == q.rx_byte) begin
                  queue_verdict(KIND_OK, 1'b0, reply_six, ~(reply_six[0] ^ cfg_polarity));
                  relay_busy = 1'b0;
                  clear_reply_progress();
               end else begin
                  clear_reply_progress();
                  queue_frame(1'b1);
               end
            end
            OP_TIMEOUT: begin
               tmo_tally = tmo_tally + 1'b1;
               clear_reply_progress();
               if (tmo_tally >= cfg_timeout_limit) begin
                  queue_verdict(KIND_FAIL, 1'b1, 8'h00, 1'b0);
                  relay_busy = 1'b0;
                  tmo_tally = '0;
               end else begin
                  queue_frame(1'b0);
               end
            end
            default: begin
               queue_verdict(KIND_FAIL, 1'b0, 8'h00, 1'b0);
               relay_busy = 1'b0;
               clear_reply_progress();
            end
         endcase
      end
   endfunction

   function automatic void push_request(op_type op, logic [7:0] address, logic [7:0] command,
                                        logic [7:0] rx);
      relay_request_type q;
      q.op = op;
      q.address = address;
      q.command = command;
      q.rx_byte = rx;
      requests_todo.push_back(q);
   endfunction

   function automatic void push_start();
      logic [7:0] command;
      case ($urandom_range(0, 3))
         0: command = CMD_ON;
         1: command = CMD_OFF;
         2: command = CMD_QUERY;
         default: command = rand_byte();
      endcase
      push_request(OP_START, rand_byte(), command, rand_byte());
   endfunction

   function automatic void push_reply_bytes(int count);
      int i;
      for (i = 0; i < count; i++) push_request(OP_BYTE, rand_byte(), rand_byte(), rand_byte());
   endfunction

   function automatic void push_reply(bit good);
      logic [7:0] sum;
      logic [7:0] b;
      int         i;
      sum = 8'h00;
      for (i = 0; i < FRAME_BYTES - 1; i++) begin
         b = rand_byte();
         sum = sum + b;
         push_request(OP_BYTE, rand_byte(), rand_byte(), b);
      end
      if (!good) sum = sum ^ 8'($urandom_range(1, 255));
      push_request(OP_BYTE, rand_byte(), rand_byte(), sum);
   endfunction

   function automatic int add_random_traffic(int target);
      int added;
      int k;
      int i;
      added = 0;
      while (added < target) begin
         if ($urandom_range(0, 99) < 85) begin
            push_start();
            added++;
         end
         k = $urandom_range(0, 99);
         if (k < 45) begin
            push_reply(1'b1);
            added += FRAME_BYTES;
         end else if (k < 60) begin
            push_reply(1'b0);
            push_reply(1'b1);
            added += 2 * FRAME_BYTES;
         end else if (k < 72) begin
            k = $urandom_range(0, FRAME_BYTES - 1);
            push_reply_bytes(k);
            push_request(OP_TIMEOUT, rand_byte(), rand_byte(), rand_byte());
            added += k + 1;
         end else if (k < 80) begin
            k = $urandom_range(1, int'(cfg_timeout_limit) + 1);
            for (i = 0; i < k; i++)
               push_request(OP_TIMEOUT, rand_byte(), rand_byte(), rand_byte());
            added += k;
         end else if (k < 86) begin
            k = $urandom_range(0, FRAME_BYTES - 1);
            push_reply_bytes(k);
            push_request(OP_LINE_ERROR, rand_byte(), rand_byte(), rand_byte());
            added += k + 1;
         end else if (k < 92) begin
            k = $urandom_range(1, FRAME_BYTES - 1);
            push_reply_bytes(k);
            added += k;
         end else begin
            k = $urandom_range(1, 4);
            for (i = 0; i < k; i++)
               push_request(op_type'($urandom_range(0, 3)), rand_byte(), rand_byte(),
                            rand_byte());
            added += k;
         end
      end
      return added;
   endfunction

   task automatic wait_idle();
      while (requests_todo.size() != 0 || req_valid || relay_results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(reg_type r, logic [3:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({r, 2'b00});
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (r == REG_TIMEOUT_LIMIT) cfg_timeout_limit = value;
      else cfg_polarity = value[0];
   endtask

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         failures++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            relay_engine_step(drive_item);
            requests_sent++;
         end
         if (!req_valid || req_ready) begin
            if (requests_todo.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 7)) begin
               drive_item = requests_todo.pop_front();
               req_valid <= 1'b1;
               req_op <= drive_item.op;
               req_board_address <= drive_item.address;
               req_command_code <= drive_item.command;
               req_rx_byte <= drive_item.rx_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(gaps_on && $urandom_range(0, 99) < 7);
      end
   end

   // result monitor
   always @(posedge clock) begin
      relay_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (relay_results_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d tx %0h",
                     $time, rsp_kind, rsp_tx_byte);
            failures++;
         end else begin
            want = relay_results_due.pop_front();
            check_field("kind", 8'(want.kind), 8'(rsp_kind));
            check_field("tx_byte", want.tx_byte, rsp_tx_byte);
            check_field("frame_end", 8'(want.frame_end), 8'(rsp_frame_end));
            check_field("flush_line", 8'(want.flush_line), 8'(rsp_flush_line));
            check_field("reply_status_byte", want.status, rsp_reply_status_byte);
            check_field("switch_closed", 8'(want.switch_closed), 8'(rsp_switch_closed));
         end
         case (rsp_kind)
            KIND_TX: tx_seen++;
            KIND_OK: done_seen++;
            default: failed_seen++;
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      logic [7:0] sum;
      logic [7:0] fixed_reply [8];
      int         i;
      int         random_items;
      random_items = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // idle noise, full good exchange, start while busy, line error, timeouts to limit
      push_request(OP_BYTE, 8'h00, 8'h00, 8'hFF);
      push_request(OP_TIMEOUT, 8'hFF, 8'hFF, 8'h00);
      push_request(OP_LINE_ERROR, 8'h00, 8'hFF, 8'h00);
      push_request(OP_START, 8'h00, CMD_ON, 8'h00);
      fixed_reply = '{8'h00, 8'hFF, 8'h5A, 8'h01, 8'h80, 8'h33, 8'hFE, 8'h7F};
      sum = 8'h00;
      for (i = 0; i < 8; i++) begin
         sum = sum + fixed_reply[i];
         push_request(OP_BYTE, 8'h00, 8'h00, fixed_reply[i]);
      end
      push_request(OP_BYTE, 8'h00, 8'h00, sum);
      push_request(OP_START, 8'hFF, CMD_OFF, 8'h00);
      push_request(OP_START, 8'h80, CMD_QUERY, 8'h00);
      push_request(OP_LINE_ERROR, 8'h00, 8'h00, 8'h00);
      push_request(OP_START, 8'h3C, 8'hFF, 8'h00);
      repeat (3) push_request(OP_TIMEOUT, 8'h00, 8'h00, 8'h00);
      wait_idle();

      // zero limit: first timeout fails
      csr_write(REG_TIMEOUT_LIMIT, 4'd0);
      push_request(OP_START, 8'h55, 8'hAA, 8'h00);
      push_request(OP_TIMEOUT, 8'h00, 8'h00, 8'h00);
      push_request(OP_TIMEOUT, 8'h00, 8'h00, 8'h00);
      wait_idle();

      csr_write(REG_TIMEOUT_LIMIT, 4'd1);
      csr_write(REG_SWITCH_POLARITY, 4'd1);
      random_items += add_random_traffic(15);
      wait_idle();

      // steady stretch without idle cycles
      gaps_on = 1'b0;
      csr_write(REG_TIMEOUT_LIMIT, 4'd15);
      csr_write(REG_SWITCH_POLARITY, 4'd0);
      random_items += add_random_traffic(15);
      wait_idle();
      gaps_on = 1'b1;

      // receiver holds off while starts keep coming
      csr_write(REG_TIMEOUT_LIMIT, 4'd5);
      csr_write(REG_SWITCH_POLARITY, 4'd1);
      hold_token++;
      repeat (6) push_start();
      random_items += add_random_traffic(15);
      wait_idle();
      random_items += add_random_traffic(10);
      wait_idle();

      $display("Ran %0d requests (%0d random) over timeout limits 0, 1, 3, 5, 15",
               requests_sent, random_items);
      $display("and both polarities; checked %0d frame bytes, %0d completions, %0d failures.",
               tx_seen, done_seen, failed_seen);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/rcre_pkg.sv
hw/rtl/rcre_fifo.sv
hw/rtl/rcre_front.sv
hw/rtl/rcre_back.sv
hw/rtl/relay_command_retry_engine.sv
bench/relay_command_retry_engine_tb.sv
